### sv/pnbp_pkg.sv
// package for the path-based neural branch predictor: widths, defaults, codes and states
`default_nettype none

package pnbp_pkg;

  localparam int PC_W      = 32;
  localparam int MCNT_W    = $clog2(PC_W);
  localparam int HLEN_W    = 6;
  localparam int THETA_W   = 13;
  localparam int WSUM_W    = 14;
  localparam int WEIGHT_W  = 8;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam int W_SAT_HI   = 2 ** (WEIGHT_W - 1) - 1;
  localparam int W_SAT_LO   = -(2 ** (WEIGHT_W - 1));
  localparam int WSUM_MAX   = 2 ** (WSUM_W - 1) - 1;
  localparam int WSUM_MIN   = -(2 ** (WSUM_W - 1));

  localparam int HIST_SLOTS_DEF  = 1024;
  localparam int W_ROWS_DEF      = 256;
  localparam int MAX_HISTORY_DEF = 32;

  localparam logic [HLEN_W-1:0]  HLEN_RESET  = HLEN_W'(32);
  localparam logic [THETA_W-1:0] THETA_RESET = THETA_W'(75);

  typedef enum logic {
    REG_HIST_LEN = 1'b0,
    REG_THETA    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_HIST,
    ST_SUM,
    ST_DECIDE,
    ST_TRAIN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

### sv/pnbp_ram.sv
// generic simple dual-port ram with one write port and a registered read port
`default_nettype none

module pnbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/path_neural_branch_predictor.sv
// top level of the path-based neural branch predictor with its sequencer and datapath
//
//  channel  | ports                                        | transaction
//  ---------+----------------------------------------------+------------------------------
//  in       | in_valid, in_stall, in_pc, in_taken          | one resolved branch
//  out      | out_valid, out_stall, out_predict_taken,     | one prediction per branch
//           | out_weight_sum, out_trained                  |
//  config   | psel, penable, pwrite, paddr, pwdata,        | history length at 0, theta at 4
//           | prdata, pready                               |
//
//  a branch runs a summing pass over the bias and L weights, then a training pass when
//  training is needed (L = active history length); the next branch can be taken in the
//  same cycle the result appears; a pc-to-slot reduction step runs first when HIST_SLOTS
//  is not a power of two; each pass reads one weight per cycle on the single weight ram read port
//  after reset a clearing pass over max(W_ROWS*(MAX_HISTORY+1), HIST_SLOTS) addresses
//  zeroes the weight and history rams; config writes are taken meanwhile
//  in_stall is high during the clearing pass and whenever a branch is in progress;
//  a result waits in the output register under out_stall while the next branch is accepted
`default_nettype none

module path_neural_branch_predictor
  import pnbp_pkg::*;
#(
  parameter int HIST_SLOTS  = HIST_SLOTS_DEF,
  parameter int W_ROWS      = W_ROWS_DEF,
  parameter int MAX_HISTORY = MAX_HISTORY_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [PC_W-1:0]           in_pc,
  input  wire logic                      in_taken,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_predict_taken,
  output logic signed [WSUM_W-1:0]       out_weight_sum,
  output logic                           out_trained,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [APB_AW-1:0]         paddr,
  input  wire logic [APB_DW-1:0]         pwdata,
  output logic      [APB_DW-1:0]         prdata,
  output logic                           pready
);

  localparam int ROW_LEN   = MAX_HISTORY + 1;
  localparam int W_DEPTH   = W_ROWS * ROW_LEN;
  localparam int W_AW      = $clog2(W_DEPTH);
  localparam int B_AW      = $clog2(HIST_SLOTS);
  localparam int R_W       = $clog2(W_ROWS);
  localparam int LEN_W     = $clog2(MAX_HISTORY + 1);
  localparam int HI_W      = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int SUM_W     = $clog2(ROW_LEN * (2 ** (WEIGHT_W - 1)) + 1) + 1;
  localparam int CMP_W     = ((SUM_W > THETA_W) ? SUM_W : THETA_W) + 2;
  localparam int CLR_DEPTH = (W_DEPTH > HIST_SLOTS) ? W_DEPTH : HIST_SLOTS;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);
  localparam bit BHT_POW2  = ((HIST_SLOTS & (HIST_SLOTS - 1)) == 0);

  state_t state_r, state_nxt;

  logic [CLR_AW-1:0]      clr_r, clr_nxt;
  logic [HLEN_W-1:0]      hlen_r, hlen_nxt;
  logic [THETA_W-1:0]     theta_r, theta_nxt;
  logic [LEN_W-1:0]       k_r, k_nxt;
  logic [MCNT_W-1:0]      mcnt_r, mcnt_nxt;
  logic [PC_W-1:0]        pc_r, pc_nxt;
  logic [B_AW-1:0]        slot_r, slot_nxt;
  logic [R_W-1:0]         row_r, row_nxt;
  logic                   taken_r, taken_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [W_AW-1:0]        prev_addr_r, prev_addr_nxt;
  logic [R_W-1:0]         path_r [MAX_HISTORY];
  logic [R_W-1:0]         path_nxt [MAX_HISTORY];
  logic [R_W-1:0]         scan_r [MAX_HISTORY];
  logic [R_W-1:0]         scan_nxt [MAX_HISTORY];
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_pred_r, out_pred_nxt;
  logic signed [WSUM_W-1:0] out_sum_r, out_sum_nxt;
  logic                   out_trained_r, out_trained_nxt;

  // sequencer outputs
  logic in_accept, cfg_wr, fin_go, clr_last, mod_last, pass_last;
  logic bias_sel, scan_load, scan_shift, h_re, h_we, w_re, w_we;

  // datapath
  logic [LEN_W-1:0]        len_eff;
  logic [R_W:0]            row_raw;
  logic [R_W-1:0]          row_in;
  logic [B_AW:0]           mod_t;
  logic [B_AW-1:0]         mod_step;
  logic [R_W-1:0]          row_sel;
  logic [W_AW-1:0]         col_sel;
  logic [W_AW-1:0]         w_raddr;
  logic [W_AW-1:0]         w_waddr;
  logic [WEIGHT_W-1:0]     w_wdata;
  logic [WEIGHT_W-1:0]     w_rdata;
  logic signed [WEIGHT_W-1:0] w_q;
  logic signed [WEIGHT_W-1:0] w_new;
  logic [B_AW-1:0]         h_waddr;
  logic [MAX_HISTORY-1:0]  h_wdata;
  logic [MAX_HISTORY-1:0]  h_rdata;
  logic [MAX_HISTORY-1:0]  h_mask;
  logic [LEN_W-1:0]        jdx;
  logic                    hbit, elem_up;
  logic signed [SUM_W-1:0] w_ext;
  logic signed [CMP_W-1:0] sum_c, th_c;
  logic                    pred, train;
  logic signed [WSUM_W-1:0] shown;

  assign in_accept = in_valid && !in_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign clr_last  = (clr_r == CLR_AW'(CLR_DEPTH - 1));
  assign mod_last  = (mcnt_r == MCNT_W'(PC_W - 1));
  assign pass_last = (k_r == len_eff);
  assign fin_go    = (state_r == ST_FINISH) && !(out_valid_r && out_stall);

  assign len_eff = (hlen_r > HLEN_W'(MAX_HISTORY)) ? LEN_W'(MAX_HISTORY) : LEN_W'(hlen_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = BHT_POW2 ? ST_HIST : ST_MOD;
      end
      ST_MOD: begin
        if (mod_last) state_nxt = ST_HIST;
      end
      ST_HIST: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (pass_last) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = train ? ST_TRAIN : ST_FINISH;
      end
      ST_TRAIN: begin
        if (pass_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall   = 1'b1;
    bias_sel   = 1'b0;
    scan_load  = 1'b0;
    scan_shift = 1'b0;
    h_re       = 1'b0;
    h_we       = 1'b0;
    w_re       = 1'b0;
    w_we       = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        h_we = ({1'b0, clr_r} < (CLR_AW + 1)'(HIST_SLOTS));
        w_we = ({1'b0, clr_r} < (CLR_AW + 1)'(W_DEPTH));
      end
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_MOD: begin
      end
      ST_HIST: begin
        h_re      = 1'b1;
        bias_sel  = 1'b1;
        scan_load = 1'b1;
        w_re      = 1'b1;
      end
      ST_DECIDE: begin
        bias_sel  = 1'b1;
        scan_load = 1'b1;
        w_re      = 1'b1;
      end
      ST_SUM: begin
        scan_shift = 1'b1;
        w_re       = !pass_last;
      end
      ST_TRAIN: begin
        scan_shift = 1'b1;
        w_re       = !pass_last;
        w_we       = 1'b1;
      end
      ST_FINISH: begin
        h_we = fin_go;
      end
      default: begin
      end
    endcase
  end

  // row of the weight table and one step of the pc reduction by HIST_SLOTS
  assign row_raw  = {1'b0, in_pc[R_W-1:0]};
  assign row_in   = (row_raw >= (R_W + 1)'(W_ROWS)) ? R_W'(row_raw - (R_W + 1)'(W_ROWS))
                                                   : row_raw[R_W-1:0];
  assign mod_t    = {slot_r, pc_r[PC_W-1]};
  assign mod_step = (mod_t >= (B_AW + 1)'(HIST_SLOTS)) ? B_AW'(mod_t - (B_AW + 1)'(HIST_SLOTS))
                                                      : mod_t[B_AW-1:0];

  // shared weight address unit
  assign row_sel = bias_sel ? row_r : scan_r[0];
  assign col_sel = bias_sel ? '0 : W_AW'(W_AW'(k_r) + W_AW'(1));
  assign w_raddr = W_AW'(W_AW'(row_sel) * W_AW'(ROW_LEN) + col_sel);

  assign w_q   = $signed(w_rdata);
  assign w_ext = SUM_W'(w_q);
  assign jdx   = LEN_W'(k_r - LEN_W'(1));
  assign hbit  = (k_r != '0) && h_rdata[jdx[HI_W-1:0]];
  assign elem_up = (k_r == '0) ? taken_r : (hbit == taken_r);

  always_comb begin
    w_new = w_q;
    if (elem_up) begin
      if (w_q != WEIGHT_W'(W_SAT_HI)) w_new = w_q + WEIGHT_W'(1);
    end else begin
      if (w_q != WEIGHT_W'(W_SAT_LO)) w_new = w_q - WEIGHT_W'(1);
    end
  end

  assign sum_c = CMP_W'(sum_r);
  assign th_c  = $signed(CMP_W'(theta_r));
  assign pred  = !sum_r[SUM_W-1];
  assign train = (pred != taken_r) || ((sum_c > -th_c) && (sum_c < th_c));
  assign shown = (sum_c > $signed(CMP_W'(WSUM_MAX))) ? WSUM_W'(WSUM_MAX) :
                 (sum_c < $signed(CMP_W'(WSUM_MIN))) ? WSUM_W'(WSUM_MIN) :
                 WSUM_W'(sum_r);

  always_comb begin
    for (int j = 0; j < MAX_HISTORY; j++) begin
      h_mask[j] = (LEN_W'(j) < len_eff);
    end
  end

  assign h_waddr = (state_r == ST_CLEAR) ? B_AW'(clr_r) : slot_r;
  assign h_wdata = (state_r == ST_CLEAR) ? '0 : (MAX_HISTORY'({h_rdata, taken_r}) & h_mask);
  assign w_waddr = (state_r == ST_CLEAR) ? W_AW'(clr_r) : prev_addr_r;
  assign w_wdata = (state_r == ST_CLEAR) ? '0 : w_new;

  // register next values
  always_comb begin
    clr_nxt         = clr_r;
    hlen_nxt        = hlen_r;
    theta_nxt       = theta_r;
    k_nxt           = k_r;
    mcnt_nxt        = mcnt_r;
    pc_nxt          = pc_r;
    slot_nxt        = slot_r;
    row_nxt         = row_r;
    taken_nxt       = taken_r;
    sum_nxt         = sum_r;
    prev_addr_nxt   = prev_addr_r;
    path_nxt        = path_r;
    scan_nxt        = scan_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_pred_nxt    = out_pred_r;
    out_sum_nxt     = out_sum_r;
    out_trained_nxt = out_trained_r;

    if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_HIST_LEN: hlen_nxt  = pwdata[HLEN_W-1:0];
        REG_THETA:    theta_nxt = pwdata[THETA_W-1:0];
        default:      hlen_nxt  = hlen_r;
      endcase
    end

    if (state_r == ST_CLEAR) clr_nxt = CLR_AW'(clr_r + CLR_AW'(1));

    if (in_accept) begin
      pc_nxt    = in_pc;
      taken_nxt = in_taken;
      row_nxt   = row_in;
      slot_nxt  = BHT_POW2 ? in_pc[B_AW-1:0] : '0;
      mcnt_nxt  = '0;
    end

    if (state_r == ST_MOD) begin
      slot_nxt = mod_step;
      pc_nxt   = {pc_r[PC_W-2:0], 1'b0};
      mcnt_nxt = MCNT_W'(mcnt_r + MCNT_W'(1));
    end

    if (w_re) prev_addr_nxt = w_raddr;

    if (scan_load) begin
      scan_nxt = path_r;
      k_nxt    = '0;
    end else if (scan_shift) begin
      for (int j = 0; j < MAX_HISTORY - 1; j++) begin
        scan_nxt[j] = scan_r[j + 1];
      end
      scan_nxt[MAX_HISTORY - 1] = '0;
      k_nxt = LEN_W'(k_r + LEN_W'(1));
    end

    if (state_r == ST_SUM) begin
      if (k_r == '0) sum_nxt = w_ext;
      else if (hbit) sum_nxt = SUM_W'(sum_r + w_ext);
      else sum_nxt = SUM_W'(sum_r - w_ext);
    end

    if (fin_go) begin
      path_nxt[0] = row_r;
      for (int j = 1; j < MAX_HISTORY; j++) begin
        path_nxt[j] = path_r[j - 1];
      end
      out_valid_nxt   = 1'b1;
      out_pred_nxt    = pred;
      out_sum_nxt     = shown;
      out_trained_nxt = train;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      hlen_r      <= HLEN_RESET;
      theta_r     <= THETA_RESET;
      k_r         <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < MAX_HISTORY; j++) begin
        path_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hlen_r      <= hlen_nxt;
      theta_r     <= theta_nxt;
      k_r         <= k_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
      path_r      <= path_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pc_r          <= pc_nxt;
    slot_r        <= slot_nxt;
    row_r         <= row_nxt;
    taken_r       <= taken_nxt;
    sum_r         <= sum_nxt;
    prev_addr_r   <= prev_addr_nxt;
    scan_r        <= scan_nxt;
    out_pred_r    <= out_pred_nxt;
    out_sum_r     <= out_sum_nxt;
    out_trained_r <= out_trained_nxt;
  end

  pnbp_ram #(
    .WIDTH (MAX_HISTORY),
    .DEPTH (HIST_SLOTS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (slot_r),
    .rdata (h_rdata)
  );

  pnbp_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (W_DEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .re    (w_re),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_predict_taken = out_pred_r;
  assign out_weight_sum    = out_sum_r;
  assign out_trained       = out_trained_r;

  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[2]))
      REG_HIST_LEN: prdata = APB_DW'(hlen_r);
      REG_THETA:    prdata = APB_DW'(theta_r);
      default:      prdata = '0;
    endcase
  end

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result appeared without a finishing step");

  a_weight_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    w_we |-> (state_r == ST_CLEAR || state_r == ST_TRAIN))
    else $error("weight ram written outside clear or training");

  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM || state_r == ST_TRAIN) |-> (k_r <= len_eff))
    else $error("weight pass counter ran past history length");

  a_sign_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pred_r == !out_sum_r[WSUM_W-1]))
    else $error("prediction disagrees with sum sign");

endmodule

`default_nettype wire
